// ----- rtl/core/clfl_pkg.sv -----
// Shared codes and controller/datapath interface types for the cursor list manager.
package clfl_pkg;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_DELETE  = 2'd1;
    localparam logic [1:0] OP_EXTRACT = 2'd2;
    localparam logic [1:0] OP_WALK    = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef logic [2:0] rkind_t;

    localparam rkind_t RK_FULL    = 3'd0;
    localparam rkind_t RK_EMPTY   = 3'd1;
    localparam rkind_t RK_INSERT  = 3'd2;
    localparam rkind_t RK_NODE    = 3'd3;
    localparam rkind_t RK_EXTRACT = 3'd4;

    typedef struct packed {
        logic   clr_step;
        logic   latch;
        logic   rd;
        logic   ins_commit;
        logic   del_commit;
        logic   x_move;
        logic   x_keep;
        logic   x_fix;
        logic   w_next;
        logic   emit;
        rkind_t kind;
        logic   emit_last;
    } cmd_t;

    typedef struct packed {
        logic cur_null;
        logic link_null;
        logic tag_match;
        logic prev_null;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/core/clfl_datapath.sv -----
// Node store, list heads, walk cursor and output word register.
module clfl_datapath
    import clfl_pkg::*;
#(
    parameter int NODE_COUNT    = 32,
    parameter int PAYLOAD_WIDTH = 64,
    parameter int TAG_WIDTH     = 8
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cmd_t                                 cmd,
    output sts_t                                 sts,
    input  logic                                 list_select,
    input  logic [1:0]                           opcode,
    input  logic [PAYLOAD_WIDTH-1:0]             payload,
    input  logic [TAG_WIDTH-1:0]                 group_tag,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic [$clog2(NODE_COUNT)-1:0]        node_index,
    output logic [PAYLOAD_WIDTH-1:0]             node_payload,
    output logic [TAG_WIDTH-1:0]                 node_group,
    output logic [$clog2(NODE_COUNT+1)-1:0]      moved_count,
    output logic                                 last
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int LINK_W = $clog2(NODE_COUNT + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NODE_COUNT);

    logic [LINK_W-1:0]        link_mem [NODE_COUNT];
    logic [PAYLOAD_WIDTH-1:0] pay_mem  [NODE_COUNT];
    logic [TAG_WIDTH-1:0]     grp_mem  [NODE_COUNT];

    logic [LINK_W-1:0]        link_q;
    logic [PAYLOAD_WIDTH-1:0] pay_q;
    logic [TAG_WIDTH-1:0]     grp_q;

    logic [LINK_W-1:0]        free_head_reg;
    logic [LINK_W-1:0]        main_head_reg;
    logic [LINK_W-1:0]        ext_head_reg;
    logic [LINK_W-1:0]        cur_reg;
    logic [LINK_W-1:0]        prev_reg;
    logic [LINK_W-1:0]        moved_reg;
    logic [IDX_W-1:0]         clr_cnt_reg;
    logic                     sel_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic [TAG_WIDTH-1:0]     tag_reg;
    logic                     out_valid_reg;

    logic                     link_we;
    logic [IDX_W-1:0]         link_wa;
    logic [LINK_W-1:0]        link_wd;
    logic [LINK_W-1:0]        cur_init;

    logic [1:0]               status_next;
    logic [IDX_W-1:0]         node_index_next;
    logic [PAYLOAD_WIDTH-1:0] node_payload_next;
    logic [TAG_WIDTH-1:0]     node_group_next;
    logic [LINK_W-1:0]        moved_count_next;
    logic                     last_next;

    assign sts.cur_null  = (cur_reg == NIL);
    assign sts.link_null = (link_q == NIL);
    assign sts.tag_match = (grp_q == tag_reg);
    assign sts.prev_null = (prev_reg == NIL);
    assign sts.clr_last  = (clr_cnt_reg == IDX_W'(NODE_COUNT - 1));
    assign sts.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        unique case (opcode)
            OP_INSERT:  cur_init = free_head_reg;
            OP_EXTRACT: cur_init = main_head_reg;
            OP_DELETE,
            OP_WALK:    cur_init = list_select ? ext_head_reg : main_head_reg;
        endcase
    end

    always_comb
    begin
        link_we = 1'b0;
        link_wa = cur_reg[IDX_W-1:0];
        link_wd = main_head_reg;
        priority if (cmd.clr_step)
        begin
            link_we = 1'b1;
            link_wa = clr_cnt_reg;
            link_wd = sts.clr_last ? NIL : LINK_W'(clr_cnt_reg) + LINK_W'(1);
        end
        else if (cmd.ins_commit)
        begin
            link_we = 1'b1;
            link_wd = main_head_reg;
        end
        else if (cmd.del_commit)
        begin
            link_we = 1'b1;
            link_wd = free_head_reg;
        end
        else if (cmd.x_move)
        begin
            link_we = 1'b1;
            link_wd = ext_head_reg;
        end
        else if (cmd.x_fix)
        begin
            link_we = 1'b1;
            link_wa = prev_reg[IDX_W-1:0];
            link_wd = cur_reg;
        end
    end

    // node store, one write and one registered read per array
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_wa] <= link_wd;
        if (cmd.ins_commit)
        begin
            pay_mem[cur_reg[IDX_W-1:0]] <= pay_reg;
            grp_mem[cur_reg[IDX_W-1:0]] <= tag_reg;
        end
        if (cmd.rd)
        begin
            link_q <= link_mem[cur_reg[IDX_W-1:0]];
            pay_q  <= pay_mem[cur_reg[IDX_W-1:0]];
            grp_q  <= grp_mem[cur_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            sel_reg <= list_select;
            pay_reg <= payload;
            tag_reg <= group_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            main_head_reg <= NIL;
            ext_head_reg  <= NIL;
            cur_reg       <= NIL;
            prev_reg      <= NIL;
            moved_reg     <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            if (cmd.latch)
            begin
                cur_reg   <= cur_init;
                prev_reg  <= NIL;
                moved_reg <= '0;
            end
            if (cmd.ins_commit)
            begin
                free_head_reg <= link_q;
                main_head_reg <= cur_reg;
            end
            if (cmd.del_commit)
            begin
                free_head_reg <= cur_reg;
                if (sel_reg)
                    ext_head_reg <= link_q;
                else
                    main_head_reg <= link_q;
            end
            if (cmd.x_move)
            begin
                ext_head_reg <= cur_reg;
                moved_reg    <= moved_reg + LINK_W'(1);
                cur_reg      <= link_q;
                if (sts.prev_null)
                    main_head_reg <= link_q;
            end
            if (cmd.x_keep)
            begin
                prev_reg <= cur_reg;
                cur_reg  <= link_q;
            end
            if (cmd.w_next)
                cur_reg <= link_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        status_next       = STAT_OK;
        node_index_next   = '0;
        node_payload_next = '0;
        node_group_next   = '0;
        moved_count_next  = '0;
        last_next         = 1'b1;
        unique case (cmd.kind)
            RK_FULL:
                status_next = STAT_FULL;
            RK_EMPTY:
                status_next = STAT_EMPTY;
            RK_INSERT:
                node_index_next = cur_reg[IDX_W-1:0];
            RK_NODE:
            begin
                node_index_next   = cur_reg[IDX_W-1:0];
                node_payload_next = pay_q;
                node_group_next   = grp_q;
                last_next         = cmd.emit_last;
            end
            RK_EXTRACT:
            begin
                node_index_next  = (ext_head_reg == NIL) ? '0 : ext_head_reg[IDX_W-1:0];
                moved_count_next = moved_reg;
            end
            default:
                status_next = STAT_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status       <= status_next;
            node_index   <= node_index_next;
            node_payload <= node_payload_next;
            node_group   <= node_group_next;
            moved_count  <= moved_count_next;
            last         <= last_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/clfl_ctrl.sv -----
// Operation sequencer for the cursor list manager.
module clfl_ctrl
    import clfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  sts_t       sts,
    output cmd_t       cmd
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_INS   = 4'd2;
    localparam logic [3:0] ST_INS2  = 4'd3;
    localparam logic [3:0] ST_DEL   = 4'd4;
    localparam logic [3:0] ST_DEL2  = 4'd5;
    localparam logic [3:0] ST_XRD   = 4'd6;
    localparam logic [3:0] ST_XEV   = 4'd7;
    localparam logic [3:0] ST_XFIX  = 4'd8;
    localparam logic [3:0] ST_WRD   = 4'd9;
    localparam logic [3:0] ST_WOUT  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    unique case (opcode)
                        OP_INSERT:  state_next = ST_INS;
                        OP_DELETE:  state_next = ST_DEL;
                        OP_EXTRACT: state_next = ST_XRD;
                        OP_WALK:    state_next = ST_WRD;
                    endcase
                end
            end
            ST_INS:
            begin
                if (!sts.cur_null)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_INS2;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = RK_FULL;
                    state_next = ST_IDLE;
                end
            end
            ST_INS2:
            begin
                if (sts.out_free)
                begin
                    cmd.ins_commit = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.kind       = RK_INSERT;
                    state_next     = ST_IDLE;
                end
            end
            ST_DEL:
            begin
                if (!sts.cur_null)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_DEL2;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = RK_EMPTY;
                    state_next = ST_IDLE;
                end
            end
            ST_DEL2:
            begin
                if (sts.out_free)
                begin
                    cmd.del_commit = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.kind       = RK_NODE;
                    cmd.emit_last  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_XRD:
            begin
                if (!sts.cur_null)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_XEV;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = RK_EXTRACT;
                    state_next = ST_IDLE;
                end
            end
            ST_XEV:
            begin
                if (sts.tag_match)
                begin
                    cmd.x_move = 1'b1;
                    state_next = sts.prev_null ? ST_XRD : ST_XFIX;
                end
                else
                begin
                    cmd.x_keep = 1'b1;
                    state_next = ST_XRD;
                end
            end
            ST_XFIX:
            begin
                cmd.x_fix  = 1'b1;
                state_next = ST_XRD;
            end
            ST_WRD:
            begin
                if (!sts.cur_null)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_WOUT;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = RK_EMPTY;
                    state_next = ST_IDLE;
                end
            end
            ST_WOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = RK_NODE;
                    cmd.emit_last = sts.link_null;
                    cmd.w_next    = 1'b1;
                    state_next    = sts.link_null ? ST_IDLE : ST_WRD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_rd_live_node: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> !sts.cur_null)
        else $error("read issued at the null link");

    a_fix_has_prev: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_XFIX) |-> !sts.prev_null)
        else $error("relink without a predecessor");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("word loaded over an untaken word");

    a_one_link_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_step, cmd.ins_commit, cmd.del_commit, cmd.x_move, cmd.x_fix}))
        else $error("two link writes in one cycle");

endmodule

// ----- rtl/core/cursor_list_free_list_manager.sv -----
// Top level of the cursor list manager: free list, main list and extracted list.
// After reset the block runs an initialization pass over the link store, during
// which in_stall stays high. One item is worked at a time. After the accept step,
// insert and delete read the head node and then commit it and emit the word (or emit
// a status word instead when the store is full or the list is empty), walk reads and
// emits each node in turn, and extract reads and evaluates each node, with an extra
// relink step for a moved node that is not at the list front. A stalled output word
// holds the operation at the step that emits the next word.
// Every node visit goes through the node store's registered read. A finished word
// waits in an output register, so the next item is accepted while it is still stalled.
module cursor_list_free_list_manager
    import clfl_pkg::*;
#(
    parameter int NODE_COUNT    = 32,
    parameter int PAYLOAD_WIDTH = 64,
    parameter int TAG_WIDTH     = 8
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           opcode,
    input  logic                                 list_select,
    input  logic [PAYLOAD_WIDTH-1:0]             payload,
    input  logic [TAG_WIDTH-1:0]                 group_tag,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic [$clog2(NODE_COUNT)-1:0]        node_index,
    output logic [PAYLOAD_WIDTH-1:0]             node_payload,
    output logic [TAG_WIDTH-1:0]                 node_group,
    output logic [$clog2(NODE_COUNT+1)-1:0]      moved_count,
    output logic                                 last
);

    cmd_t cmd;
    sts_t sts;

    clfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    clfl_datapath #(
        .NODE_COUNT    (NODE_COUNT),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .TAG_WIDTH     (TAG_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .list_select  (list_select),
        .opcode       (opcode),
        .payload      (payload),
        .group_tag    (group_tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .node_index   (node_index),
        .node_payload (node_payload),
        .node_group   (node_group),
        .moved_count  (moved_count),
        .last         (last)
    );

endmodule
